/* rtl/core/sopg_pkg.sv */
package sopg_pkg;

  localparam int MaxPoints    = 64;
  localparam int CordicStages = 16;
  localparam int CntW         = 7;
  localparam int CorW         = 34;
  localparam int ZW           = 32;
  localparam int QW           = 32;

  localparam logic [CorW-1:0] KQ30       = CorW'(652032874);
  localparam logic [31:0]     HalfPiQ30  = 32'd1686629713;

  typedef enum logic [1:0] {
    TypeCircle = 2'd0,
    TypeSquare = 2'd1,
    TypeLine   = 2'd2,
    TypeBad    = 2'd3
  } req_type_e;

  // Arctangent table in Q30, indexed by rotation step; entries 0 to 23 are defined
  function automatic logic [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:  v = 32'd843314857;
      5'd1:  v = 32'd497837829;
      5'd2:  v = 32'd263043837;
      5'd3:  v = 32'd133525159;
      5'd4:  v = 32'd67021687;
      5'd5:  v = 32'd33543516;
      5'd6:  v = 32'd16775851;
      5'd7:  v = 32'd8388437;
      5'd8:  v = 32'd4194283;
      5'd9:  v = 32'd2097149;
      5'd10: v = 32'd1048576;
      5'd11: v = 32'd524288;
      5'd12: v = 32'd262144;
      5'd13: v = 32'd131072;
      5'd14: v = 32'd65536;
      5'd15: v = 32'd32768;
      5'd16: v = 32'd16384;
      5'd17: v = 32'd8192;
      5'd18: v = 32'd4096;
      5'd19: v = 32'd2048;
      5'd20: v = 32'd1024;
      5'd21: v = 32'd512;
      5'd22: v = 32'd256;
      5'd23: v = 32'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturate a wide signed value to 16 bits
  function automatic logic [15:0] sat16(input logic signed [39:0] v);
    logic [15:0] r;
    if (v > 40'sd32767)       r = 16'h7fff;
    else if (v < -40'sd32768) r = 16'h8000;
    else                      r = v[15:0];
    return r;
  endfunction

endpackage

/* rtl/core/shape_outline_point_generator.sv */
// Sequence: a circle point takes one serial division and one CORDIC rotation,
// a square or line point two serial divisions; a rejected request is answered
// from the check state without any division.
// Flow: one request at a time; each further point repeats the same steps,
// and any output stall holds it back.
// Reset: rst_ni clears the sequencer and output valid; no data is cleared.
module shape_outline_point_generator
  import sopg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // req_type[1:0], pos_x[17:2], pos_y[33:18], end_x[49:34], end_y[65:50],
  // size[80:66], count[87:81]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // point_x[15:0], point_y[31:16]
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tuser,  // error
  output logic        m_axis_tlast
);

  typedef enum logic [3:0] {
    StIdle, StCheck, StDivA, StWaitA, StCord, StWaitC,
    StDivX, StWaitX, StDivY, StWaitY, StEmit, StOut
  } state_e;

  state_e state_q;
  logic [1:0]         typ_q;
  logic signed [15:0] px_q, py_q, ex_q, ey_q;
  logic [14:0]        sz_q;
  logic [CntW-1:0]    n_q, k_q;
  logic [1:0]         e_q;
  logic [6:0]         idx_q, total_q;
  logic signed [39:0] ox_q, oy_q;
  logic [1:0]         quad_q;
  logic               neg_q, sel_y_q;
  logic [QW-1:0]      div_num_q, div_den_q;
  logic               div_go_q, cor_go_q;
  logic [15:0]        outx_q, outy_q;
  logic               oerr_q, olast_q, ovalid_q;
  logic signed [CorW-1:0] x0_q;
  logic signed [ZW-1:0]   z0_q;

  logic          div_done, cor_done;
  logic [QW-1:0] quo, rem;
  logic signed [CorW-1:0] cx, cy;

  sopg_div u_div (
    .clk_i, .rst_ni, .start_i(div_go_q), .num_i(div_num_q), .den_i(div_den_q),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  sopg_cordic u_cordic (
    .clk_i, .rst_ni, .start_i(cor_go_q), .x0_i(x0_q), .z0_i(z0_q),
    .done_o(cor_done), .x_o(cx), .y_o(cy)
  );

  // Numerator for square and line: offset scaled by 2n or by n
  logic signed [39:0] num_x, num_y, den_s;
  logic signed [39:0] half, step, dlx, dly;
  logic signed [15:0] cr, sr;
  logic signed [39:0] qsig;
  logic [QW-1:0]      absn;
  logic [21:0]        ang_r;
  logic [53:0]        zprod;

  assign half  = 40'($signed({1'b0, n_q})) * 40'($signed({1'b0, sz_q}));
  assign step  = 40'($signed({1'b0, k_q})) * 40'($signed({1'b0, sz_q})) * 40'sd2;
  assign dlx   = 40'($signed({1'b0, k_q})) * (40'(ex_q) - 40'(px_q));
  assign dly   = 40'($signed({1'b0, k_q})) * (40'(ey_q) - 40'(py_q));
  assign ang_r = quo[21:0];
  assign zprod = 54'(ang_r) * 54'(HalfPiQ30);
  assign cr    = 16'((cx + CorW'(32768)) >>> 16);
  assign sr    = 16'((cy + CorW'(32768)) >>> 16);

  always_comb begin
    num_x = '0;
    num_y = '0;
    den_s = 40'($signed({1'b0, n_q}));
    if (typ_q == TypeSquare) begin
      den_s = 40'($signed({1'b0, n_q})) * 40'sd2;
      case (e_q)
        2'd0:    begin num_x = half - step;  num_y = half;         end
        2'd1:    begin num_x = -half;        num_y = half - step;  end
        2'd2:    begin num_x = -half + step; num_y = -half;        end
        default: begin num_x = half;         num_y = -half + step; end
      endcase
    end else begin
      num_x = dlx;
      num_y = dly;
    end
  end

  // Floor of (2m + d) / 2d via magnitude division and sign fix-up
  logic signed [39:0] rnd_num;
  assign rnd_num = 40'sd2 * (sel_y_q ? num_y : num_x) + den_s;
  assign absn    = rnd_num[39] ? QW'(-rnd_num) : QW'(rnd_num);
  assign qsig    = neg_q ? ((rem != '0) ? -40'(quo) - 40'sd1 : -40'(quo)) : 40'(quo);

  logic bad;
  always_comb begin
    case (typ_q)
      TypeCircle: bad = (n_q < 7'd2) || (n_q > 7'(MaxPoints));
      TypeSquare: bad = (n_q < 7'd4) || ({n_q, 2'b00} > 9'(MaxPoints));
      TypeLine:   bad = (n_q < 7'd1) || (n_q > 7'(MaxPoints));
      default:    bad = 1'b1;
    endcase
  end

  logic               hold;
  assign hold = ovalid_q && !m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
      div_go_q <= 1'b0;
      cor_go_q <= 1'b0;
    end else begin
      div_go_q <= 1'b0;
      cor_go_q <= 1'b0;
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      case (state_q)
        StIdle: if (s_axis_tvalid) begin
          typ_q   <= s_axis_tdata[1:0];
          px_q    <= s_axis_tdata[17:2];
          py_q    <= s_axis_tdata[33:18];
          ex_q    <= s_axis_tdata[49:34];
          ey_q    <= s_axis_tdata[65:50];
          sz_q    <= s_axis_tdata[80:66];
          n_q     <= s_axis_tdata[87:81];
          k_q     <= '0;
          e_q     <= '0;
          idx_q   <= '0;
          sel_y_q <= 1'b0;
          state_q <= StCheck;
        end
        StCheck: if (!hold) begin
          if (bad) begin
            outx_q   <= '0;
            outy_q   <= '0;
            oerr_q   <= 1'b1;
            olast_q  <= 1'b1;
            ovalid_q <= 1'b1;
            state_q  <= StIdle;
          end else begin
            total_q <= (typ_q == TypeSquare) ? {n_q[4:0], 2'b00} : n_q;
            state_q <= (typ_q == TypeCircle) ? StDivA : StDivX;
          end
        end
        // Angle fraction: k * 2^24 / n
        StDivA: begin
          div_num_q <= QW'({k_q, 24'b0});
          div_den_q <= QW'(n_q);
          div_go_q  <= 1'b1;
          state_q   <= StWaitA;
        end
        StWaitA: if (div_done) begin
          quad_q  <= quo[23:22];
          state_q <= StCord;
        end
        StCord: begin
          z0_q     <= ZW'(zprod >> 22);
          x0_q     <= CorW'((48'(sz_q) * 48'(KQ30)) >> 14);
          cor_go_q <= 1'b1;
          state_q  <= StWaitC;
        end
        StWaitC: if (cor_done) begin
          case (quad_q)
            2'd0:    begin ox_q <= 40'(cr);  oy_q <= 40'(sr);  end
            2'd1:    begin ox_q <= -40'(sr); oy_q <= 40'(cr);  end
            2'd2:    begin ox_q <= -40'(cr); oy_q <= -40'(sr); end
            default: begin ox_q <= 40'(sr);  oy_q <= -40'(cr); end
          endcase
          state_q <= StEmit;
        end
        // Launch the x division, keep the numerator sign
        StDivX: begin
          div_num_q <= absn;
          div_den_q <= QW'(den_s * 40'sd2);
          div_go_q  <= 1'b1;
          neg_q     <= rnd_num[39];
          state_q   <= StWaitX;
        end
        StWaitX: if (div_done) begin
          ox_q    <= qsig;
          sel_y_q <= 1'b1;
          state_q <= StDivY;
        end
        StDivY: begin
          div_num_q <= absn;
          div_den_q <= QW'(den_s * 40'sd2);
          div_go_q  <= 1'b1;
          neg_q     <= rnd_num[39];
          sel_y_q   <= 1'b0;
          state_q   <= StWaitY;
        end
        StWaitY: if (div_done) begin
          oy_q    <= qsig;
          state_q <= StEmit;
        end
        StEmit: if (!hold) begin
          outx_q   <= sat16(40'(px_q) + ox_q);
          outy_q   <= sat16(40'(py_q) + oy_q);
          oerr_q   <= 1'b0;
          olast_q  <= (idx_q == total_q - 7'd1);
          ovalid_q <= 1'b1;
          state_q  <= StOut;
        end
        StOut: begin
          idx_q <= idx_q + 7'd1;
          if (idx_q == total_q - 7'd1) begin
            state_q <= StIdle;
          end else begin
            if (k_q == n_q - 7'd1) begin
              k_q <= '0;
              e_q <= e_q + 2'd1;
            end else begin
              k_q <= k_q + 7'd1;
            end
            state_q <= (typ_q == TypeCircle) ? StDivA : StDivX;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {outy_q, outx_q};
  assign m_axis_tuser  = oerr_q;
  assign m_axis_tlast  = olast_q;

  // Output payload holds while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(m_axis_tvalid && !m_axis_tready) |-> $stable(m_axis_tdata))
    else $error("output changed under stall");
  // Error results always end their request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("error without last");
  // Divider and CORDIC never started together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_go_q && cor_go_q))
    else $error("units started together");

endmodule

/* rtl/core/sopg_div.sv */
// Bit-serial restoring divider: unsigned numerator over unsigned divisor.
module sopg_div
  import sopg_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [QW-1:0] num_i,
  input  logic [QW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o,
  output logic [QW-1:0] rem_o
);

  logic [QW-1:0] quo_q, rem_q, den_q;
  logic [5:0]    cnt_q;
  logic          busy_q, done_q;
  logic [QW:0]   trial;

  assign trial = {rem_q, quo_q[QW-1]} - {1'b0, den_q};

  // Shift one quotient bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (!trial[QW]) begin
        rem_q <= trial[QW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[QW-2:0], quo_q[QW-1]};
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

/* rtl/core/sopg_cordic.sv */
// Rotation-mode CORDIC, one stage per cycle on one shared set of x, y and z adders.
module sopg_cordic
  import sopg_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [CorW-1:0] x0_i,
  input  logic signed [ZW-1:0]   z0_i,
  output logic                   done_o,
  output logic signed [CorW-1:0] x_o,
  output logic signed [CorW-1:0] y_o
);

  logic signed [CorW-1:0] x_q, y_q;
  logic signed [ZW-1:0]   z_q;
  logic [4:0]             i_q;
  logic                   busy_q, done_q;
  logic signed [CorW-1:0] dx, dy;

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 5'd1;
        if (i_q == 5'(CordicStages - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Rotate toward zero residual angle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x0_i;
      y_q <= '0;
      z_q <= z0_i;
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - $signed(atan_q30(i_q));
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + $signed(atan_q30(i_q));
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;

endmodule

/* verif/shape_outline_point_generator_test.sv */
module shape_outline_point_generator_test;
  import sopg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_type_e          kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [14:0]        size;
    logic [6:0]         count;
  } shape_req_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    logic        err;
    logic        last;
  } outline_point_t;

  // Arctangent of 2^-i in Q30, angles in radians of the rotation steps
  localparam longint AtanTab [16] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768};

  // Outline point predictor and store of points still due
  class outline_board;
    outline_point_t due_q[$];
    int unsigned    fails;
    int unsigned    n_reqs;
    int unsigned    n_points;
    int unsigned    n_rejects;

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint round_div(longint n, longint d);
      return floor_div(2 * n + d, 2 * d);
    endfunction

    function logic [15:0] clip16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function void push_point(longint x, longint y, logic err, logic last);
      outline_point_t p;
      p.x = clip16(x);
      p.y = clip16(y);
      p.err = err;
      p.last = last;
      due_q.push_back(p);
    endfunction

    // Rotate radius by 2*pi*k/n through quadrant select and CORDIC
    function void circle_offset(longint rad, longint k, longint n,
                                output longint ox, output longint oy);
      longint ang, frac, z, x, y, dx, dy, c, s;
      logic [1:0] quad;
      ang  = (k << 24) / n;
      quad = ang[23:22];
      frac = ang & 64'h3fffff;
      z    = (frac * longint'(HalfPiQ30)) >>> 22;
      x    = (rad * longint'(KQ30)) >>> 14;
      y    = 0;
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= AtanTab[i];
        end else begin
          x += dx; y -= dy; z += AtanTab[i];
        end
      end
      c = (x + 32768) >>> 16;
      s = (y + 32768) >>> 16;
      case (quad)
        2'd0: begin ox = c;  oy = s;  end
        2'd1: begin ox = -s; oy = c;  end
        2'd2: begin ox = -c; oy = -s; end
        default: begin ox = s; oy = -c; end
      endcase
    endfunction

    // Expand one accepted request into its outline points
    function void note_request(shape_req_t r);
      longint n, px, py, sz, half, stp, ox, oy;
      int total;
      n  = r.count;
      px = r.pos_x;
      py = r.pos_y;
      sz = r.size;
      n_reqs++;
      if ((r.kind == TypeCircle && (n < 2 || n > MaxPoints)) ||
          (r.kind == TypeSquare && (n < 4 || 4 * n > MaxPoints)) ||
          (r.kind == TypeLine && (n < 1 || n > MaxPoints)) ||
          r.kind == TypeBad) begin
        n_rejects++;
        push_point(0, 0, 1'b1, 1'b1);
        return;
      end
      total = int'((r.kind == TypeSquare) ? 4 * n : n);
      n_points += unsigned'(total);
      for (int idx = 0; idx < total; idx++) begin
        case (r.kind)
          TypeCircle: begin
            circle_offset(sz, idx, n, ox, oy);
            push_point(px + ox, py + oy, 1'b0, idx == total - 1);
          end
          TypeSquare: begin
            half = n * sz;
            stp  = 2 * (idx % n) * sz;
            case (idx / n)
              0: begin ox = half - stp; oy = half; end
              1: begin ox = -half; oy = half - stp; end
              2: begin ox = -half + stp; oy = -half; end
              default: begin ox = half; oy = -half + stp; end
            endcase
            push_point(px + round_div(ox, 2 * n), py + round_div(oy, 2 * n),
                       1'b0, idx == total - 1);
          end
          default: begin
            push_point(px + round_div(idx * (longint'(r.end_x) - px), n),
                       py + round_div(idx * (longint'(r.end_y) - py), n),
                       1'b0, idx == total - 1);
          end
        endcase
      end
    endfunction

    // Compare one output beat against the oldest point due
    function void check_point(logic [15:0] x, logic [15:0] y, logic err, logic last);
      outline_point_t e;
      if (due_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected beat x=%h y=%h err=%b last=%b", $time, x, y, err, last);
        return;
      end
      e = due_q.pop_front();
      if (e.x !== x || e.y !== y || e.err !== err || e.last !== last) begin
        fails++;
        $display("%0t: mismatch expected x=%h y=%h err=%b last=%b, got x=%h y=%h err=%b last=%b",
                 $time, e.x, e.y, e.err, e.last, x, y, err, last);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  outline_board board;
  bit           steady_send;
  bit           steady_recv;
  bit           hold_done;
  int unsigned  beats_seen;

  shape_outline_point_generator u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function shape_req_t mk_req(req_type_e kind, int px, int py, int ex, int ey,
                              int sz, int cnt);
    shape_req_t r;
    r.kind  = kind;
    r.pos_x = px[15:0];
    r.pos_y = py[15:0];
    r.end_x = ex[15:0];
    r.end_y = ey[15:0];
    r.size  = sz[14:0];
    r.count = cnt[6:0];
    return r;
  endfunction

  // Random request: mostly valid shapes with small counts, some bad ones
  function shape_req_t rand_req();
    shape_req_t r;
    int pick;
    pick = $urandom_range(0, 19);
    r.pos_x = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
    r.pos_y = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 8191) - 4096);
    r.end_x = 16'($urandom);
    r.end_y = 16'($urandom);
    r.size  = $urandom_range(0, 3) == 0 ? 15'($urandom) : 15'($urandom_range(0, 4095));
    if (pick < 6) begin
      r.kind  = TypeCircle;
      r.count = $urandom_range(0, 9) == 0 ? 7'($urandom_range(9, 64))
                                          : 7'($urandom_range(2, 8));
    end else if (pick < 11) begin
      r.kind  = TypeSquare;
      r.count = $urandom_range(0, 5) == 0 ? 7'($urandom_range(7, 16))
                                          : 7'($urandom_range(4, 6));
    end else if (pick < 17) begin
      r.kind  = TypeLine;
      r.count = $urandom_range(0, 9) == 0 ? 7'($urandom_range(9, 64))
                                          : 7'($urandom_range(1, 8));
      if ($urandom_range(0, 7) == 0) begin
        r.end_x = r.pos_x;
        r.end_y = r.pos_y;
      end
    end else begin
      r.kind  = req_type_e'($urandom_range(0, 3));
      r.count = 7'($urandom);
    end
    return r;
  endfunction

  // Offer one request after a random gap (none in steady mode) and hold it until taken
  task automatic send_req(shape_req_t r);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {r.count, r.size, r.end_y, r.end_x, r.pos_y, r.pos_x, r.kind};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(r);
    @(negedge clk_i);
  endtask

  // Output side: random stalls, one long hold-off to back up the block
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && beats_seen >= 30) begin
        hold_done = 1'b1;
        stall = 2000;
      end else begin
        stall = steady_recv ? 0 : $urandom_range(0, 14);
      end
      if ($urandom_range(0, 39) == 0) steady_recv = ~steady_recv;
      m_axis_tready = 1'b0;
      repeat (stall) @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      beats_seen++;
      board.check_point(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tuser, m_axis_tlast);
    end
  end

  // Watchdog
  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    shape_req_t dir_q[$];
    int guard;
    board = new();
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: count limits, every shape, bad type, saturation, degenerate line
    dir_q.push_back(mk_req(TypeCircle, 0, 0, 0, 0, 256, 2));
    dir_q.push_back(mk_req(TypeCircle, 100, -100, 0, 0, 32767, 64));
    dir_q.push_back(mk_req(TypeCircle, 0, 0, 0, 0, 0, 4));
    dir_q.push_back(mk_req(TypeCircle, 32767, -32768, 0, 0, 32767, 8));
    dir_q.push_back(mk_req(TypeCircle, 0, 0, 0, 0, 256, 1));
    dir_q.push_back(mk_req(TypeCircle, 0, 0, 0, 0, 256, 0));
    dir_q.push_back(mk_req(TypeCircle, 0, 0, 0, 0, 256, 65));
    dir_q.push_back(mk_req(TypeSquare, 0, 0, 0, 0, 512, 4));
    dir_q.push_back(mk_req(TypeSquare, -32768, 32767, 0, 0, 32767, 16));
    dir_q.push_back(mk_req(TypeSquare, 0, 0, 0, 0, 333, 5));
    dir_q.push_back(mk_req(TypeSquare, 0, 0, 0, 0, 512, 3));
    dir_q.push_back(mk_req(TypeSquare, 0, 0, 0, 0, 512, 17));
    dir_q.push_back(mk_req(TypeLine, -32768, -32768, 32767, 32767, 0, 64));
    dir_q.push_back(mk_req(TypeLine, 10, 20, 10, 20, 0, 5));
    dir_q.push_back(mk_req(TypeLine, 0, 0, -7, 3, 0, 1));
    dir_q.push_back(mk_req(TypeLine, 0, 0, 1, -1, 32767, 3));
    dir_q.push_back(mk_req(TypeLine, 0, 0, 100, 100, 0, 0));
    dir_q.push_back(mk_req(TypeLine, 0, 0, 100, 100, 0, 127));
    dir_q.push_back(mk_req(TypeBad, 1, 2, 3, 4, 5, 10));
    dir_q.push_back(mk_req(TypeBad, -1, -1, -1, -1, 32767, 127));
    foreach (dir_q[i]) send_req(dir_q[i]);

    // Random part with bursts of back-to-back offers
    for (int i = 0; i < 220; i++) begin
      if ($urandom_range(0, 19) == 0) steady_send = ~steady_send;
      send_req(rand_req());
    end
    s_axis_tvalid = 1'b0;

    // Drain, then watch for stray beats
    while (board.due_q.size() != 0) @(posedge clk_i);
    guard = 0;
    while (guard < 300) begin
      @(posedge clk_i);
      guard++;
    end

    $display("Ran %0d requests: %0d outline points and %0d rejected requests checked.",
             board.n_reqs, board.n_points, board.n_rejects);
    $display("Shapes covered circle, square, line and bad type with random stalls on both sides.");
    if (board.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
